@@ rtl/rzt_pkg.sv @@
package rzt_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_DRAIN
    } state_t;

    localparam logic        KIND_LOAD    = 1'b0;
    localparam logic        KIND_POS     = 1'b1;

    localparam logic [1:0]  USE_UNUSED   = 2'd0;
    localparam logic [1:0]  USE_GLOBAL   = 2'd1;
    localparam logic [1:0]  USE_PLAYER   = 2'd2;

    localparam logic [15:0] ZONE_MISSING = 16'hFFFF;

endpackage

@@ rtl/rzt_ram.sv @@
module rzt_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  logic [WIDTH-1:0]      wdata,
    input  logic                  re,
    input  logic [AW-1:0]         raddr,
    output logic [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/rect_zone_enter_leave_tracker.sv @@
// a position update keeps busy high through the sweep and the drain; the sweep ends early when a
// reserved zone is met; each event is held until the next is found or the sweep ends
// throughput: one slot read per cycle; a new position update is taken only once busy has dropped
// a load never raises busy; the receiver cannot stall
// reset: tracking enabled, all slots unused with inside flags clear (per-slot valid
// bits), no sweep in progress
module rect_zone_enter_leave_tracker
    import rzt_pkg::*;
#(
    parameter int ZONE_SLOTS = 64,
    parameter int COORD_BITS = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         start,
    output logic                         busy,
    input  logic                         kind,
    input  logic [5:0]                   slot,
    input  logic [1:0]                   slot_use,
    input  logic [15:0]                  zone_number,
    input  logic signed [COORD_BITS-1:0] min_x,
    input  logic signed [COORD_BITS-1:0] min_y,
    input  logic signed [COORD_BITS-1:0] max_x,
    input  logic signed [COORD_BITS-1:0] max_y,
    input  logic signed [COORD_BITS-1:0] pos_x,
    input  logic signed [COORD_BITS-1:0] pos_y,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_data,

    output logic                         event_valid,
    output logic                         event_leave,
    output logic                         zone_is_player,
    output logic [15:0]                  event_zone,
    output logic [5:0]                   event_slot,
    output logic                         last
);

    localparam int AW   = (ZONE_SLOTS > 1) ? $clog2(ZONE_SLOTS) : 1;
    localparam int CB   = COORD_BITS;
    localparam int WW   = 1 + 2 + 16 + 4 * CB;
    localparam int F_FL = WW - 1;
    localparam int F_US = WW - 2;
    localparam int F_ZN = WW - 4;

    state_t                 state_reg, state_next;
    logic [AW-1:0]          rd_cnt_reg, rd_cnt_next;
    logic                   ev_valid_reg, ev_valid_next;
    logic                   ev_entry_reg;
    logic [AW-1:0]          ev_idx_reg;
    logic signed [CB-1:0]   pos_x_reg, pos_y_reg;
    logic                   pend_valid_reg, pend_valid_next;
    logic                   pend_leave_reg, pend_player_reg;
    logic [15:0]            pend_zone_reg;
    logic [AW-1:0]          pend_idx_reg;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_leave_reg, out_player_reg, out_last_reg;
    logic [15:0]            out_zone_reg;
    logic [AW-1:0]          out_idx_reg;
    logic                   enable_reg;
    logic [ZONE_SLOTS-1:0]  valid_reg;

    logic                   load_go, pos_go, issue, last_issue, flush;
    logic                   used, stop, change, in_rect, flag;
    logic [1:0]             ev_use;
    logic [15:0]            ev_zone;
    logic signed [CB-1:0]   lx, ly, hx, hy;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [WW-1:0]          ram_wdata, ram_rdata;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign load_go   = start && !busy && (kind == KIND_LOAD)
                       && ({1'b0, slot} < 7'(ZONE_SLOTS));
    assign pos_go    = start && !busy && (kind == KIND_POS) && enable_reg;
    assign issue     = (state_reg == S_SWEEP);
    assign last_issue = issue && (rd_cnt_reg == AW'(ZONE_SLOTS - 1));
    assign flush     = (state_reg == S_DRAIN) && !ev_valid_reg;

    // evaluation of the slot read last cycle
    assign ev_use  = ev_entry_reg ? ram_rdata[F_US -: 2] : USE_UNUSED;
    assign ev_zone = ram_rdata[F_ZN -: 16];
    assign flag    = ev_entry_reg && ram_rdata[F_FL];
    assign lx      = ram_rdata[4*CB-1 -: CB];
    assign ly      = ram_rdata[3*CB-1 -: CB];
    assign hx      = ram_rdata[2*CB-1 -: CB];
    assign hy      = ram_rdata[CB-1 -: CB];
    assign used    = (ev_use == USE_GLOBAL) || (ev_use == USE_PLAYER);
    assign stop    = ev_valid_reg && used && (ev_zone == ZONE_MISSING);
    assign in_rect = (pos_x_reg >= lx) && (pos_x_reg <= hx)
                     && (pos_y_reg >= ly) && (pos_y_reg <= hy);
    assign change  = ev_valid_reg && used && !stop && (in_rect != flag);

    assign ram_we    = load_go || change;
    assign ram_waddr = load_go ? slot[AW-1:0] : ev_idx_reg;
    assign ram_wdata = load_go
        ? {1'b0, slot_use, zone_number, min_x, min_y, max_x, max_y}
        : {in_rect, ram_rdata[F_US:0]};

    rzt_ram #(
        .WIDTH (WW),
        .DEPTH (ZONE_SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (rd_cnt_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pos_go)
                begin
                    state_next = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                if (stop || last_issue)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (flush)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rd_cnt_next     = issue ? rd_cnt_reg + AW'(1) : rd_cnt_reg;
        if (pos_go)
        begin
            rd_cnt_next = '0;
        end
        ev_valid_next   = issue && !stop;
        pend_valid_next = pend_valid_reg;
        if (change)
        begin
            pend_valid_next = 1'b1;
        end
        else if (flush)
        begin
            pend_valid_next = 1'b0;
        end
        out_valid_next  = pend_valid_reg && (change || flush);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rd_cnt_reg     <= '0;
            ev_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            enable_reg     <= 1'b1;
            valid_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_cnt_reg     <= rd_cnt_next;
            ev_valid_reg   <= ev_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                enable_reg <= cfg_data;
            end
            if (load_go)
            begin
                valid_reg[slot[AW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pos_go)
        begin
            pos_x_reg <= pos_x;
            pos_y_reg <= pos_y;
        end
        if (issue)
        begin
            ev_entry_reg <= valid_reg[rd_cnt_reg];
            ev_idx_reg   <= rd_cnt_reg;
        end
        if (change)
        begin
            pend_leave_reg  <= !in_rect;
            pend_player_reg <= (ev_use == USE_PLAYER);
            pend_zone_reg   <= ev_zone;
            pend_idx_reg    <= ev_idx_reg;
        end
        if (out_valid_next)
        begin
            out_leave_reg  <= pend_leave_reg;
            out_player_reg <= pend_player_reg;
            out_zone_reg   <= pend_zone_reg;
            out_idx_reg    <= pend_idx_reg;
            out_last_reg   <= flush;
        end
    end

    assign event_valid    = out_valid_reg;
    assign event_leave    = out_leave_reg;
    assign zone_is_player = out_player_reg;
    assign event_zone     = out_zone_reg;
    assign event_slot     = 6'(out_idx_reg);
    assign last           = out_last_reg;

endmodule

@@ rtl/rzt_checker.sv @@
module rzt_checker
    import rzt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  logic kind,
    input  logic event_valid,
    input  logic last
);

    // an event other than the last keeps the sweep running
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && !last |-> busy)
        else $error("event before last shown while idle");

    // the last event is shown as the block returns to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && last |-> !busy)
        else $error("last event shown while still busy");

    // a load never starts a sweep
    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (kind == KIND_LOAD) |=> !busy)
        else $error("load transaction raised busy");

    // events only follow a busy cycle
    a_event_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid |-> $past(busy))
        else $error("event without a sweep");

endmodule

bind rect_zone_enter_leave_tracker rzt_checker u_rzt_checker (.*);
